// ===== rtl/core/cdll_pkg.sv =====
// action and status codes shared by the cursor linked list core
`timescale 1ns / 1ps

package cdll_pkg;

   localparam int ACTION_WIDTH = 4;
   localparam int STATUS_WIDTH = 2;

   // action codes
   localparam logic [ACTION_WIDTH-1:0] ACT_FIRST       = 4'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_NEXT        = 4'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_LAST        = 4'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_PREV        = 4'd3;
   localparam logic [ACTION_WIDTH-1:0] ACT_PUSH_FRONT  = 4'd4;
   localparam logic [ACTION_WIDTH-1:0] ACT_PUSH_BACK   = 4'd5;
   localparam logic [ACTION_WIDTH-1:0] ACT_PUSH_AFTER  = 4'd6;
   localparam logic [ACTION_WIDTH-1:0] ACT_POP_FRONT   = 4'd7;
   localparam logic [ACTION_WIDTH-1:0] ACT_POP_BACK    = 4'd8;
   localparam logic [ACTION_WIDTH-1:0] ACT_POP_CURSOR  = 4'd9;
   localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR       = 4'd10;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STAT_NONE  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STAT_FULL  = 2'd2;

endpackage

// ===== rtl/core/cdll_ram.sv =====
// simple dual-port ram with one write port and a registered read port
`timescale 1ns / 1ps

module cdll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/cursor_doubly_linked_list_core.sv =====
// top level of the cursor doubly linked list: control sequencer and node memories
`timescale 1ns / 1ps

// Doubly linked list of up to CAPACITY entries with a cursor. Nodes live in three
// synchronous memories (data, next link, previous link) with a registered read
// port; head, tail, cursor, free list head, fresh index and entry count are
// registers. An action transfer is taken when start is high and busy is low; busy
// stays high while the sequencer works on it, and exactly one result follows on
// rsp_valid for a single cycle. The receiver cannot stall: the result is gone
// after that cycle. Each action passes through S_READ, where first, last, clear,
// unused codes, every failing action and push_front into an empty list end;
// push_front otherwise and the pops go on to S_WRITE2, next and prev to S_READ2,
// and push_back and push_after_cursor on a non-empty list through S_READ2 to
// S_WRITE2. These steps are set by the memory read latency (the cursor's links
// must be read before a neighbor can be touched) and by the single write port of
// each link memory, which splits the relinking of a node across separate write
// states. A new action may be accepted in the same cycle that the previous result
// is shown. The pointer value CAPACITY means none. No clearing pass after reset:
// node entries are only read after they have been written.

module cursor_doubly_linked_list_core #(
   parameter int CAPACITY   = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // action channel
   input  logic                              start,
   output logic                              busy,
   input  logic [cdll_pkg::ACTION_WIDTH-1:0] req_action,
   input  logic [DATA_WIDTH-1:0]             req_data_in,
   // result channel
   output logic                              rsp_valid,
   output logic [cdll_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic [DATA_WIDTH-1:0]             rsp_data_out,
   output logic [$clog2(CAPACITY+1)-1:0]     rsp_count
);

   import cdll_pkg::*;

   localparam int PW = $clog2(CAPACITY + 1);  // pointer width, holds none
   localparam int IW = $clog2(CAPACITY);      // node index width
   localparam logic [PW-1:0] NIL = PW'(CAPACITY);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_READ   = 4'b0010,
      S_READ2  = 4'b0100,
      S_WRITE2 = 4'b1000
   } state_type;

   function automatic logic is_node(input logic [PW-1:0] p);
      return p < NIL;
   endfunction

   // sequencer and list registers
   state_type                 state_ff, state_in;
   logic [ACTION_WIDTH-1:0]   act_ff, act_in;
   logic [DATA_WIDTH-1:0]     item_ff, item_in;     // push data, later popped data
   logic [PW-1:0]             head_ff, head_in;
   logic [PW-1:0]             tail_ff, tail_in;
   logic [PW-1:0]             cur_ff, cur_in;
   logic [PW-1:0]             free_ff, free_in;
   logic [PW-1:0]             fresh_ff, fresh_in;
   logic [PW-1:0]             count_ff, count_in;
   logic [PW-1:0]             n_ff, n_in;           // node being pushed or popped
   logic [PW-1:0]             p_ff, p_in;           // anchor or old head
   logic [PW-1:0]             x_ff, x_in;           // successor of the anchor

   // result registers
   logic                      rsp_valid_ff;
   logic [STATUS_WIDTH-1:0]   rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0]     rsp_data_ff, rsp_data_in;
   logic                      done;

   // memory ports
   logic [IW-1:0]             rd_addr;
   logic                      val_we, nxt_we, prv_we;
   logic [IW-1:0]             val_wa, nxt_wa, prv_wa;
   logic [DATA_WIDTH-1:0]     val_wd, val_rd;
   logic [PW-1:0]             nxt_wd, nxt_rd, prv_wd, prv_rd;

   // combined per-action helpers
   logic [PW-1:0]             anchor;
   logic [PW-1:0]             pop_node;
   logic [PW-1:0]             step_node;
   logic                      alloc_free;
   logic                      alloc_ok;
   logic [PW-1:0]             alloc_n;

   cdll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (val_wd),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   cdll_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_next_ram (
      .clock   (clock),
      .wr_en   (nxt_we),
      .wr_addr (nxt_wa),
      .wr_data (nxt_wd),
      .rd_addr (rd_addr),
      .rd_data (nxt_rd)
   );

   cdll_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prv_we),
      .wr_addr (prv_wa),
      .wr_data (prv_wd),
      .rd_addr (rd_addr),
      .rd_data (prv_rd)
   );

   // anchor for pushes after a node, node picked by pops, cursor step target
   assign anchor     = (act_ff == ACT_PUSH_BACK) ? tail_ff : cur_ff;
   assign pop_node   = (act_ff == ACT_POP_FRONT) ? head_ff :
                       (act_ff == ACT_POP_BACK)  ? tail_ff : cur_ff;
   assign step_node  = (act_ff == ACT_NEXT) ? nxt_rd : prv_rd;

   // node allocation: free list first, then the never-used fresh index
   assign alloc_free = is_node(free_ff);
   assign alloc_ok   = alloc_free || (fresh_ff < NIL);
   assign alloc_n    = alloc_free ? free_ff : fresh_ff;

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      item_in       = item_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cur_in        = cur_ff;
      free_in       = free_ff;
      fresh_in      = fresh_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      p_in          = p_ff;
      x_in          = x_ff;
      done          = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_data_in   = '0;
      rd_addr       = free_ff[IW-1:0];
      val_we        = 1'b0;
      val_wa        = n_ff[IW-1:0];
      val_wd        = item_ff;
      nxt_we        = 1'b0;
      nxt_wa        = n_ff[IW-1:0];
      nxt_wd        = NIL;
      prv_we        = 1'b0;
      prv_wa        = n_ff[IW-1:0];
      prv_wd        = NIL;

      unique case (state_ff)
         S_IDLE: begin
            // read the node the action starts from, straight off the request
            case (req_action) inside
               ACT_FIRST, ACT_POP_FRONT:          rd_addr = head_ff[IW-1:0];
               ACT_LAST, ACT_POP_BACK:            rd_addr = tail_ff[IW-1:0];
               ACT_NEXT, ACT_PREV, ACT_POP_CURSOR: rd_addr = cur_ff[IW-1:0];
               default:                           rd_addr = free_ff[IW-1:0];
            endcase
            if (start) begin
               act_in   = req_action;
               item_in  = req_data_in;
               state_in = S_READ;
            end
         end

         S_READ: begin
            // read address for a second access, used by steps and mid-list pushes
            rd_addr = ((act_ff == ACT_NEXT) || (act_ff == ACT_PREV)) ?
                      step_node[IW-1:0] : anchor[IW-1:0];
            unique case (act_ff) inside
               ACT_FIRST, ACT_LAST: begin
                  done = 1'b1;
                  if (!is_node(head_ff)) begin
                     rsp_status_in = STAT_NONE;
                  end else begin
                     cur_in      = (act_ff == ACT_FIRST) ? head_ff : tail_ff;
                     rsp_data_in = val_rd;
                  end
               end

               ACT_NEXT, ACT_PREV: begin
                  if (!is_node(cur_ff)) begin
                     done          = 1'b1;
                     rsp_status_in = STAT_NONE;
                  end else if (!is_node(step_node)) begin
                     // stepped off an end of the list
                     done          = 1'b1;
                     rsp_status_in = STAT_NONE;
                     cur_in        = NIL;
                  end else begin
                     cur_in   = step_node;
                     state_in = S_READ2;
                  end
               end

               ACT_PUSH_FRONT: begin
                  if (!alloc_ok) begin
                     done          = 1'b1;
                     rsp_status_in = STAT_FULL;
                  end else begin
                     if (alloc_free) begin
                        free_in = nxt_rd;
                     end else begin
                        fresh_in = fresh_ff + PW'(1);
                     end
                     val_we   = 1'b1;
                     val_wa   = alloc_n[IW-1:0];
                     nxt_we   = 1'b1;
                     nxt_wa   = alloc_n[IW-1:0];
                     nxt_wd   = head_ff;
                     prv_we   = 1'b1;
                     prv_wa   = alloc_n[IW-1:0];
                     prv_wd   = NIL;
                     head_in  = alloc_n;
                     count_in = count_ff + PW'(1);
                     if (!is_node(tail_ff)) begin
                        tail_in = alloc_n;
                     end
                     if (is_node(head_ff)) begin
                        // old head gets its back link in the next cycle
                        n_in     = alloc_n;
                        p_in     = head_ff;
                        state_in = S_WRITE2;
                     end else begin
                        done = 1'b1;
                     end
                  end
               end

               ACT_PUSH_BACK, ACT_PUSH_AFTER: begin
                  if (is_node(head_ff) && !is_node(anchor)) begin
                     done          = 1'b1;
                     rsp_status_in = STAT_NONE;
                  end else if (!alloc_ok) begin
                     done          = 1'b1;
                     rsp_status_in = STAT_FULL;
                  end else begin
                     if (alloc_free) begin
                        free_in = nxt_rd;
                     end else begin
                        fresh_in = fresh_ff + PW'(1);
                     end
                     if (!is_node(head_ff)) begin
                        // first entry of an empty list
                        val_we   = 1'b1;
                        val_wa   = alloc_n[IW-1:0];
                        nxt_we   = 1'b1;
                        nxt_wa   = alloc_n[IW-1:0];
                        prv_we   = 1'b1;
                        prv_wa   = alloc_n[IW-1:0];
                        head_in  = alloc_n;
                        tail_in  = alloc_n;
                        cur_in   = alloc_n;
                        count_in = count_ff + PW'(1);
                        done     = 1'b1;
                     end else begin
                        // anchor's successor is being read this cycle
                        n_in     = alloc_n;
                        p_in     = anchor;
                        state_in = S_READ2;
                     end
                  end
               end

               ACT_POP_FRONT, ACT_POP_BACK, ACT_POP_CURSOR: begin
                  cur_in = NIL;
                  if (!is_node(pop_node)) begin
                     done          = 1'b1;
                     rsp_status_in = STAT_NONE;
                  end else begin
                     // splice neighbors together, free the node next cycle
                     nxt_we  = is_node(prv_rd);
                     nxt_wa  = prv_rd[IW-1:0];
                     nxt_wd  = nxt_rd;
                     prv_we  = is_node(nxt_rd);
                     prv_wa  = nxt_rd[IW-1:0];
                     prv_wd  = prv_rd;
                     if (head_ff == pop_node) begin
                        head_in = nxt_rd;
                     end
                     if (tail_ff == pop_node) begin
                        tail_in = prv_rd;
                     end
                     if (count_ff != '0) begin
                        count_in = count_ff - PW'(1);
                     end
                     item_in  = val_rd;
                     n_in     = pop_node;
                     state_in = S_WRITE2;
                  end
               end

               ACT_CLEAR: begin
                  // whole chain goes onto the free list in front
                  if (is_node(head_ff) && is_node(tail_ff)) begin
                     nxt_we  = 1'b1;
                     nxt_wa  = tail_ff[IW-1:0];
                     nxt_wd  = free_ff;
                     free_in = head_ff;
                  end
                  head_in  = NIL;
                  tail_in  = NIL;
                  cur_in   = NIL;
                  count_in = '0;
                  done     = 1'b1;
               end

               default: begin
                  done = 1'b1;
               end
            endcase
         end

         S_READ2: begin
            if ((act_ff == ACT_NEXT) || (act_ff == ACT_PREV)) begin
               done        = 1'b1;
               rsp_data_in = val_rd;
            end else begin
               // new node sits between the anchor and its old successor
               x_in     = nxt_rd;
               cur_in   = p_ff;
               val_we   = 1'b1;
               nxt_we   = 1'b1;
               nxt_wd   = nxt_rd;
               prv_we   = 1'b1;
               prv_wd   = p_ff;
               count_in = count_ff + PW'(1);
               if (tail_ff == p_ff) begin
                  tail_in = n_ff;
               end
               state_in = S_WRITE2;
            end
         end

         S_WRITE2: begin
            done = 1'b1;
            case (act_ff) inside
               ACT_PUSH_FRONT: begin
                  prv_we = 1'b1;
                  prv_wa = p_ff[IW-1:0];
                  prv_wd = n_ff;
               end
               ACT_PUSH_BACK, ACT_PUSH_AFTER: begin
                  nxt_we = 1'b1;
                  nxt_wa = p_ff[IW-1:0];
                  nxt_wd = n_ff;
                  prv_we = is_node(x_ff);
                  prv_wa = x_ff[IW-1:0];
                  prv_wd = n_ff;
               end
               default: begin
                  // pops: freed node joins the free list
                  nxt_we      = 1'b1;
                  nxt_wa      = n_ff[IW-1:0];
                  nxt_wd      = free_ff;
                  free_in     = n_ff;
                  rsp_data_in = item_ff;
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (done) begin
         state_in = S_IDLE;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         cur_ff       <= NIL;
         free_ff      <= NIL;
         fresh_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cur_ff       <= cur_in;
         free_ff      <= free_in;
         fresh_ff     <= fresh_in;
         count_ff     <= count_in;
         rsp_valid_ff <= done;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      item_ff <= item_in;
      n_ff    <= n_in;
      p_ff    <= p_in;
      x_ff    <= x_in;
      if (done) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   // count holds still until the next action has been read, so it is valid here
   assign rsp_count    = count_ff;

endmodule
